[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rwm_pkg.sv]
// Package for the running window mean: defaults, constants and shared types.
`default_nettype none

package rwm_pkg;

  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WS_W            = 9;
  localparam int WINDOW_RESET    = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_FINISH
  } rwm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rwm_div_stat_t;

endpackage

`default_nettype wire

[rtl/rwm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module rwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/rwm_div.sv]
// Unsigned restoring divider that retires two quotient bits per cycle.
`default_nettype none

module rwm_div import rwm_pkg::*; #(
  parameter int DIVIDEND_W = 26,
  parameter int DIVISOR_W  = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output rwm_div_stat_t              stat,
  output logic      [DIVIDEND_W-1:0] quotient
);

  localparam int STEPS = (DIVIDEND_W + 1) / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIVISOR_W:0]    rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [CNT_W-1:0]      steps_left;
  logic                  done;
  logic [DIVISOR_W:0]    rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quotient;
    for (int k = 0; k < 2; k++) begin
      rem_next = {rem_next[DIVISOR_W-1:0], quo_next[DIVIDEND_W-1]};
      quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next    = rem_next - {1'b0, dsr};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      done       <= 1'b0;
    end else if (start) begin
      steps_left <= CNT_W'(STEPS);
      done       <= 1'b0;
    end else if (steps_left != '0) begin
      steps_left <= steps_left - 1'b1;
      done       <= (steps_left == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (steps_left != '0) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

  assign stat.busy = (steps_left != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

[rtl/running_window_mean.sv]
// Running window mean: averages the most recent samples held in a ring memory.
// Each sample is taken in one transfer on the s_axis side and gives exactly one
// result transfer on the m_axis side: the sum of the stored samples divided by
// their count, truncated toward zero, with tuser set while the window is still
// filling (including the sample that completes it). One sample occupies the
// block through the ring read, the sum update and ring write, the divider
// start, the two-bit-per-cycle division and the output load, and no new sample
// is taken before its result is loaded. A finished result waits in the output
// register, so the next sample is taken while it is still unclaimed.
// A write on the cfg port sets the window length (0 acts as 1, anything above
// WINDOW_MAX as WINDOW_MAX) and restarts filling; write it only while idle.
`default_nettype none

module running_window_mean import rwm_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // mean
  output logic      [0:0]             m_axis_tuser,   // filling
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [WS_W-1:0]        cfg_data
);

  localparam int AW        = $clog2(WINDOW_MAX);
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int DIV_W     = SUM_W + (SUM_W % 2);
  localparam int RESET_EFF = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  rwm_state_t state, state_next;

  logic [CNT_W-1:0]       win_eff;
  logic [CNT_W-1:0]       win_eff_next;
  logic [AW-1:0]          write_slot;
  logic [CNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]       window_sum;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic [AW-1:0]          cur_slot;
  logic                   cur_fill;
  logic                   sum_neg;

  logic                   in_xfer;
  logic                   out_load;
  logic                   ram_re;
  logic                   ram_we;
  logic                   div_start;
  logic [AW-1:0]          slot_norm;
  logic [CNT_W-1:0]       slot_inc;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       new_ext;
  logic [SUM_W-1:0]       old_ext;
  logic [SUM_W-1:0]       sum_mag;
  logic [31:0]            ws32;
  rwm_div_stat_t          div_stat;
  logic [DIV_W-1:0]       div_quo;
  logic [SAMPLE_BITS-1:0] quo_low;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // A window write clears the stored slot, so this guard only maps an out-of-range slot to zero.
  assign slot_norm = (CNT_W'(write_slot) >= win_eff) ? '0 : write_slot;
  assign slot_inc  = CNT_W'(cur_slot) + CNT_W'(1);

  assign new_ext = {{(SUM_W - SAMPLE_BITS){cur_sample[SAMPLE_BITS-1]}}, cur_sample};
  assign old_ext = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
  assign sum_mag = window_sum[SUM_W-1] ? (~window_sum + SUM_W'(1)) : window_sum;
  assign quo_low = div_quo[SAMPLE_BITS-1:0];

  always_comb begin
    ws32 = 32'(cfg_data);
    if (ws32 == 32'd0) begin
      win_eff_next = CNT_W'(1);
    end else if (ws32 > 32'(WINDOW_MAX)) begin
      win_eff_next = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff_next = CNT_W'(ws32);
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer. Only one sample is in flight, so the ring
  // write in ST_READ never meets a read of the same slot.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid;
      end
      ST_READ:   ram_we    = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_DIV:    out_load  = 1'b0;
      ST_FINISH: out_load  = !m_axis_tvalid || m_axis_tready;
      default:   out_load  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      win_eff       <= CNT_W'(RESET_EFF);
      write_slot    <= '0;
      sample_count  <= '0;
      window_sum    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        if (cur_fill) begin
          window_sum   <= window_sum + new_ext;
          sample_count <= sample_count + CNT_W'(1);
        end else begin
          window_sum <= window_sum + new_ext - old_ext;
        end
        write_slot <= (slot_inc >= win_eff) ? '0 : AW'(slot_inc);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        win_eff      <= win_eff_next;
        write_slot   <= '0;
        sample_count <= '0;
        window_sum   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      cur_slot   <= slot_norm;
      cur_fill   <= (sample_count < win_eff);
    end
    if (div_start) begin
      sum_neg <= window_sum[SUM_W-1];
    end
    if (out_load) begin
      m_axis_tdata    <= OUT_TDATA_W'(sum_neg ? (~quo_low + SAMPLE_BITS'(1)) : quo_low);
      m_axis_tuser[0] <= cur_fill;
    end
  end

  rwm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (cur_sample),
    .re    (ram_re),
    .raddr (slot_norm),
    .rdata (old_sample)
  );

  rwm_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(sum_mag)),
    .divisor  (sample_count),
    .stat     (div_stat),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

[rtl/rwm_check.sv]
// Port-level checker for the running window mean, with its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module rwm_check #(
  parameter int OUT_W = 16
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic [0:0]       m_axis_tuser
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Samples taken whose result transfer has not happened yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `ASSERT_CLK_ALWAYS(a_reset_clears_out, rst |=> !m_axis_tvalid, "result valid right after reset")
  `ASSERT_CLK(a_out_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `ASSERT_CLK(a_no_invented_result, m_axis_tvalid |-> pending != 2'd0, "result without a pending sample")
  `ASSERT_CLK(a_one_in_flight, in_xfer |=> !s_axis_tready && pending != 2'd3, "second sample taken while one is in work")

endmodule

bind running_window_mean rwm_check #(
  .OUT_W (OUT_TDATA_W)
) u_rwm_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for running_window_mean, with stalls on both stream sides.
module tb;
  import rwm_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int RING_DEPTH   = WINDOW_MAX_DEF;
  localparam int ITEM_TARGET  = 1350;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT    = 4000000;

  typedef struct {
    logic [SAMPLE_W-1:0] mean;
    logic                filling;
  } mean_result_t;

  // Tracks the window the block should hold and the means it should give back.
  class window_mean_tracker;
    logic [WS_W-1:0]     window_reg;
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int                  next_slot;
    int                  stored;
    int                  run_sum;
    mean_result_t        pending[$];
    int                  errors;
    int                  filling_seen;
    int                  full_seen;

    function new();
      window_reg   = WS_W'(WINDOW_RESET);
      errors       = 0;
      filling_seen = 0;
      full_seen    = 0;
      restart();
    endfunction

    function void restart();
      next_slot = 0;
      stored    = 0;
      run_sum   = 0;
    endfunction

    function void set_window(logic [WS_W-1:0] value);
      window_reg = value;
      restart();
    endfunction

    // Zero acts as one, anything past the ring depth is clipped to it.
    function int span();
      if (window_reg == 0) return 1;
      if (int'(window_reg) > RING_DEPTH) return RING_DEPTH;
      return int'(window_reg);
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      int           w;
      int           slot;
      mean_result_t r;
      w    = span();
      slot = next_slot;
      if (slot >= w) slot = 0;
      if (stored < w) begin
        r.filling = 1'b1;
        run_sum += int'($signed(raw));
        stored++;
      end else begin
        r.filling = 1'b0;
        run_sum += int'($signed(raw)) - int'($signed(ring[slot]));
      end
      ring[slot] = raw;
      next_slot  = (slot + 1 >= w) ? 0 : slot + 1;
      // Signed integer division truncates toward zero.
      r.mean = SAMPLE_W'(run_sum / stored);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] mean, logic filling);
      mean_result_t want;
      if (pending.size() == 0) begin
        $error("result with no sample outstanding: mean %0d filling %0b",
               $signed(mean), filling);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (want.filling) filling_seen++;
      else full_seen++;
      if (mean !== want.mean) begin
        $error("mean: expected %0d, got %0d", $signed(want.mean), $signed(mean));
        errors++;
      end
      if (filling !== want.filling) begin
        $error("filling: expected %0b, got %0b", want.filling, filling);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WS_W-1:0]     cfg_data = '0;

  window_mean_tracker tracker = new();

  int tx_idle_pct  = 26;
  int rx_idle_pct  = 73;
  bit rx_hold_req  = 1'b0;
  int rx_hold_left = 0;
  int items_sent   = 0;
  int samples_in   = 0;
  int windows_set  = 0;

  running_window_mean u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: random back-pressure, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        tracker.set_window(cfg_data);
        windows_set++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_sample(s_axis_tdata);
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tdata, m_axis_tuser[0]);
      end
    end
  end

  // Leaves tvalid high after the transfer; the next task call moves or drops it.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [WS_W-1:0] value);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Part of each run leans on one extreme so that window means reach the rails.
  task automatic run_samples(input int n, input int extreme_pct);
    logic [SAMPLE_W-1:0] value;
    logic [SAMPLE_W-1:0] rail;
    rail = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    for (int i = 0; i < n; i++) begin
      if (items_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 26;
        rx_idle_pct = 73;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 73;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (items_sent % 400 == 200) rx_hold_req = 1'b1;
      if (items_sent % 400 == 350) wait_drain();
      if ($urandom_range(0, 99) < extreme_pct) begin
        value = rail;
      end else begin
        case ($urandom_range(0, 7))
          0:       value = SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
          1:       value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default: value = SAMPLE_W'($urandom);
        endcase
      end
      send_sample(value);
    end
  endtask

  initial begin
    int              n;
    int              eff;
    logic [WS_W-1:0] w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset window of eight: fill and roll at both rails, then small and patterned values.
    repeat (9) send_sample(16'h7FFF);
    repeat (9) send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'hFFFD);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // Fixed settings: window of one, zero acting as one, windows of 2, 3 and 17,
    // the full ring, and a value past the ring depth that must clip to it.
    write_window(9'd1);
    run_samples(20, 20);
    write_window(9'd0);
    run_samples(15, 20);
    write_window(9'd2);
    run_samples(30, 30);
    write_window(9'd256);
    run_samples(290, 60);
    write_window(9'd3);
    run_samples(40, 20);
    write_window(9'd511);
    run_samples(270, 60);
    write_window(9'd17);
    run_samples(60, 30);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) w = WS_W'($urandom_range(0, 511));
      else w = WS_W'($urandom_range(1, 24));
      eff = (w == 0) ? 1 : ((int'(w) > RING_DEPTH) ? RING_DEPTH : int'(w));
      n = (eff < 32) ? eff + $urandom_range(1, 2 * eff + 10) : eff + $urandom_range(1, 20);
      write_window(w);
      run_samples(n, 25);
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples across %0d window writes, including 0, 1, 256 and 511.",
             samples_in, windows_set);
    $display("Checked %0d means while filling and %0d from a full window.",
             tracker.filling_seen, tracker.full_seen);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $error("run timed out with %0d results outstanding", tracker.pending.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rwm_pkg.sv
rtl/rwm_ram.sv
rtl/rwm_div.sv
rtl/running_window_mean.sv
rtl/rwm_check.sv
tb/tb.sv
